[rtl/core/obd_mode06_response_parser_core_macros.svh]
// Assertion macros shared by the response parser RTL.
`ifndef OBD_MODE06_RESPONSE_PARSER_CORE_MACROS_SVH
`define OBD_MODE06_RESPONSE_PARSER_CORE_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define OBD06_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define OBD06_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/obd06_pkg.sv]
// Shared constants, status codes and scaling-id lookups for the response parser.
package obd06_pkg;

    // Record limits and store sizing.
    localparam int MAX_RECORDS  = 16;
    localparam int REC_BYTES    = 9;
    localparam int STORE_DEPTH  = MAX_RECORDS * REC_BYTES;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int REC_CNT_W    = $clog2(MAX_RECORDS + 2);
    localparam int PHASE_W      = 4;

    // Field widths of a result.
    localparam int COUNT_W      = 5;
    localparam int STATUS_W     = 2;
    localparam int OUT_TDATA_W  = 88;

    // Protocol constants.
    localparam logic [7:0] HEADER_OK    = 8'h46;
    localparam logic [7:0] UNSIGNED_MIN = 8'h01;
    localparam logic [7:0] UNSIGNED_MAX = 8'h41;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MALFORMED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNEXPECTED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_MANY   = 2'd3;

    // Scaling ids whose values are two's complement.
    function automatic logic id_signed(input logic [7:0] id);
        logic r;
        unique case (id)
            8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h8A, 8'h8B,
            8'h8C, 8'h8D, 8'h8E, 8'h90, 8'h96, 8'h99, 8'h9C, 8'h9D, 8'hA8,
            8'hA9, 8'hAD, 8'hAE, 8'hAF, 8'hB0, 8'hB1, 8'hFC, 8'hFD, 8'hFE:
                r = 1'b1;
            default:
                r = 1'b0;
        endcase
        return r;
    endfunction

    // Scaling ids present in the built-in table.
    function automatic logic id_known(input logic [7:0] id);
        return ((id >= UNSIGNED_MIN) && (id <= UNSIGNED_MAX)) || id_signed(id);
    endfunction

endpackage

[rtl/core/obd06_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
module obd06_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/obd_mode06_response_parser_core.sv]
// Error status: it is registered and appears in the cycle after the last byte is taken.
// Record results: each takes nine memory reads, one drain and one check.
// Throughput: one byte per cycle while receiving and the output is free; no byte is taken while records are emitted.
// Reset (rst_n, asynchronous, active low) clears all control state and the output valid.
// The record memory is not cleared; every entry is written before it is read back.
module obd_mode06_response_parser_core
    import obd06_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,  // [7:0] data_byte
    input  logic                   s_axis_tlast,  // last_byte
    input  logic                   s_axis_tuser,  // empty_response
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] monitor_id, [15:8] test_id, [23:16] scaling_id, [39:24] test_value,
    // [55:40] lower_limit, [71:56] upper_limit, [72] scale_in_table,
    // [73] value_signed, [74] passed, [76:75] status, [81:77] record_count,
    // [87:82] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast   // last_result
);

`include "obd_mode06_response_parser_core_macros.svh"

    localparam logic [1:0] S_RECV  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_EVAL  = 2'd3;

    localparam logic [PHASE_W-1:0]   LAST_PHASE = PHASE_W'(REC_BYTES - 1);
    localparam logic [REC_CNT_W-1:0] MAX_REC    = REC_CNT_W'(MAX_RECORDS);

    logic [1:0]             state_reg, state_next;
    logic [7:0]             header_reg, header_next;
    logic                   got_header_reg, got_header_next;
    logic [PHASE_W-1:0]     phase_reg, phase_next;
    logic [REC_CNT_W-1:0]   seen_reg, seen_next;
    logic [ADDR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [PHASE_W-1:0]     byte_cnt_reg, byte_cnt_next;
    logic [REC_CNT_W-1:0]   emit_reg, emit_next;
    logic [REC_CNT_W-1:0]   count_reg, count_next;
    logic                   cap_reg, cap_next;
    logic [8*REC_BYTES-1:0] rec_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                   out_last_reg, out_last_next;

    logic                   accept;
    logic                   out_free;
    logic                   mem_we;
    logic [7:0]             mem_rdata;
    logic [7:0]             hdr_now;
    logic [PHASE_W-1:0]     phase_new;
    logic [REC_CNT_W-1:0]   seen_new;
    logic                   finish;
    logic                   load;

    // Fields of the record held for checking.
    logic [7:0]  f_monitor, f_test, f_sid;
    logic [15:0] f_value, f_min, f_max;
    logic        f_known, f_signed, f_pass;
    logic signed [16:0] n_value, n_min, n_max;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_RECV) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign mem_we        = accept && !s_axis_tuser && got_header_reg && (seen_reg < MAX_REC);

    // Record store: one byte per entry, read back in order for emission.
    obd06_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wr_ptr_reg),
        .wdata (s_axis_tdata),
        .raddr (rd_ptr_reg),
        .rdata (mem_rdata)
    );

    // Position in the response once the current byte is counted.
    always_comb
    begin
        hdr_now   = got_header_reg ? header_reg : s_axis_tdata;
        phase_new = phase_reg;
        seen_new  = seen_reg;
        if (got_header_reg)
        begin
            if (phase_reg == LAST_PHASE)
            begin
                phase_new = '0;
                if (seen_reg < REC_CNT_W'(MAX_RECORDS + 1))
                begin
                    seen_new = seen_reg + 1'b1;
                end
            end
            else
            begin
                phase_new = phase_reg + 1'b1;
            end
        end
    end

    // Record field decode and the range test, signed or unsigned as the scaling id gives.
    always_comb
    begin
        f_monitor = rec_reg[71:64];
        f_test    = rec_reg[63:56];
        f_sid     = rec_reg[55:48];
        f_value   = rec_reg[47:32];
        f_min     = rec_reg[31:16];
        f_max     = rec_reg[15:0];
        f_known   = id_known(f_sid);
        f_signed  = id_signed(f_sid);
        n_value   = {f_signed & f_value[15], f_value};
        n_min     = {f_signed & f_min[15], f_min};
        n_max     = {f_signed & f_max[15], f_max};
        f_pass    = f_known && (n_value >= n_min) && (n_value <= n_max);
    end

    assign finish = (emit_reg + 1'b1) == count_reg;
    assign load   = (state_reg == S_EVAL) && out_free;

    // Receive, fetch and emit sequencing.
    always_comb
    begin
        state_next      = state_reg;
        header_next     = header_reg;
        got_header_next = got_header_reg;
        phase_next      = phase_reg;
        seen_next       = seen_reg;
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        byte_cnt_next   = byte_cnt_reg;
        emit_next       = emit_reg;
        count_next      = count_reg;
        cap_next        = (state_reg == S_FETCH);
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            S_RECV:
            begin
                if (accept)
                begin
                    header_next     = hdr_now;
                    got_header_next = 1'b1;
                    phase_next      = phase_new;
                    seen_next       = seen_new;
                    if (mem_we)
                    begin
                        wr_ptr_next = wr_ptr_reg + 1'b1;
                    end
                    if (s_axis_tuser || s_axis_tlast)
                    begin
                        // Any end of response returns the receive state to reset.
                        header_next     = '0;
                        got_header_next = 1'b0;
                        phase_next      = '0;
                        seen_next       = '0;
                        wr_ptr_next     = '0;
                        out_data_next   = '0;
                        out_last_next   = 1'b1;
                        priority if (s_axis_tuser)
                        begin
                            out_valid_next = 1'b1;
                            out_data_next[76:75] = ST_MALFORMED;
                        end
                        else if (hdr_now != HEADER_OK)
                        begin
                            out_valid_next = 1'b1;
                            out_data_next[76:75] = ST_UNEXPECTED;
                        end
                        else if ((phase_new != '0) || (seen_new == '0))
                        begin
                            out_valid_next = 1'b1;
                            out_data_next[76:75] = ST_MALFORMED;
                        end
                        else if (seen_new > MAX_REC)
                        begin
                            out_valid_next = 1'b1;
                            out_data_next[76:75] = ST_TOO_MANY;
                        end
                        else
                        begin
                            count_next    = seen_new;
                            emit_next     = '0;
                            rd_ptr_next   = '0;
                            byte_cnt_next = '0;
                            state_next    = S_FETCH;
                        end
                    end
                end
            end
            S_FETCH:
            begin
                rd_ptr_next = rd_ptr_reg + 1'b1;
                if (byte_cnt_reg == LAST_PHASE)
                begin
                    byte_cnt_next = '0;
                    state_next    = S_DRAIN;
                end
                else
                begin
                    byte_cnt_next = byte_cnt_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = finish;
                    out_data_next  = {6'd0, COUNT_W'(count_reg), ST_OK, f_pass,
                                      f_signed, f_known, f_max, f_min, f_value,
                                      f_sid, f_test, f_monitor};
                    emit_next      = emit_reg + 1'b1;
                    state_next     = finish ? S_RECV : S_FETCH;
                end
            end
            default:
            begin
                state_next = S_RECV;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_RECV;
            header_reg     <= '0;
            got_header_reg <= 1'b0;
            phase_reg      <= '0;
            seen_reg       <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            byte_cnt_reg   <= '0;
            emit_reg       <= '0;
            count_reg      <= '0;
            cap_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            header_reg     <= header_next;
            got_header_reg <= got_header_next;
            phase_reg      <= phase_next;
            seen_reg       <= seen_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            byte_cnt_reg   <= byte_cnt_next;
            emit_reg       <= emit_next;
            count_reg      <= count_next;
            cap_reg        <= cap_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers: record assembly and the output transfer.
    always_ff @(posedge clk)
    begin
        if (cap_reg)
        begin
            rec_reg <= {rec_reg[8*REC_BYTES-9:0], mem_rdata};
        end
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // Checks on the sequencing.
    `OBD06_ASSERT_SAME(a_no_write_while_emitting, state_reg != S_RECV, !mem_we,
        "record store written while records are being emitted")
    `OBD06_ASSERT_SAME(a_write_in_range, mem_we, wr_ptr_reg < ADDR_W'(STORE_DEPTH),
        "record store write beyond its depth")
    `OBD06_ASSERT_SAME(a_emit_below_count, state_reg != S_RECV, emit_reg < count_reg,
        "emission index reached the record count")
    `OBD06_ASSERT_NEXT(a_final_returns_idle, load && finish,
        (state_reg == S_RECV) && m_axis_tvalid && m_axis_tlast,
        "final record result did not end emission")

endmodule
